// ===== hw/rtl/drive_pid_with_heading_hold_assert.svh =====
// Assertion macros for the drive PID with heading hold block.
`ifndef DRIVE_PID_WITH_HEADING_HOLD_ASSERT_SVH
`define DRIVE_PID_WITH_HEADING_HOLD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPH_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Signed value must sit inside a closed range whenever en is high.
`define DPH_ASSERT_RANGE(lbl, clk, rstn, en, val, lo, hi, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        (en) |-> (((val) >= (lo)) && ((val) <= (hi)))) else $error(msg);

`endif

// ===== hw/rtl/dph_pkg.sv =====
// Shared types, constants and the heading wrap function of the drive PID block.
`default_nettype none
package dph_pkg;

    localparam int SUM_W      = 40;
    localparam int DRIVE_W    = 18;
    localparam int TURN_W     = 10;
    localparam int HEAD_W     = 9;
    localparam int ROT_W      = 16;
    localparam int GOAL_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DEG_FULL    = 360;
    localparam int DEG_HALF    = 180;
    // 92 * 360: lifts any 16-bit rotation to a positive value
    localparam int WRAP_OFFSET = 33120;
    // ceil(2^24 / 360), exact for dividends below 74898
    localparam int WRAP_RECIP  = 46604;
    localparam int WRAP_SHIFT  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_SPEED_LIMIT  = 3'd3,
        REG_GOAL_POS     = 3'd4,
        REG_SETTLE_BAND  = 3'd5,
        REG_SETTLE_TICKS = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0]       gain_p;
        logic [15:0]       gain_i;
        logic [15:0]       gain_d;
        logic [6:0]        speed_limit;
        logic [GOAL_W-1:0] goal_position;
        logic [15:0]       settle_band;
        logic [7:0]        settle_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:        16'd768,
        gain_i:        16'd0,
        gain_d:        16'd6400,
        speed_limit:   7'd110,
        goal_position: 24'd0,
        settle_band:   16'd100,
        settle_ticks:  8'd10
    };

    // What the result of one tick carries
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_DRIVE,
        MODE_DONE
    } mode_t;

    // Wrap a signed whole-degree rotation to 0..359
    function automatic logic [HEAD_W-1:0] wrap_deg(input logic [ROT_W-1:0] rot);
        logic [16:0] u;
        logic [32:0] prod;
        logic [8:0]  q;
        logic [16:0] qm;
        logic [16:0] r;
        u    = {rot[ROT_W-1], rot} + 17'(WRAP_OFFSET);
        prod = 33'(u) * 33'(WRAP_RECIP);
        q    = prod[WRAP_SHIFT+8:WRAP_SHIFT];
        qm   = 17'(q) * 17'(DEG_FULL);
        r    = u - qm;
        return r[HEAD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/drive_pid_with_heading_hold.sv =====
// Top level of the drive PID with heading hold block.
//
// One input transaction per control tick on the s_ channel: s_tdata carries the
// encoder position and the gyro rotation, s_tuser the start request. Each input
// transaction yields exactly one result transaction on the m_ channel: left and
// right drive in 1/256 command units in m_tdata, the done flag in m_tuser.
// Gains, speed limit, goal and settle settings are written on the cfg_ channel,
// one register per transaction (index 0..6, higher indexes are dropped); the
// cfg_ready output is always high. The user must write them only while the
// block is idle; the block does not enforce this. A transaction passes through
// the input register, controller state stage, gain product register, PID sum
// register and result register. Throughput is one transaction per cycle; when
// the receiver stalls, each stage holds its transaction and the input keeps
// being taken until every stage is full. The only loop is the controller state
// stage (error, saturating integral, settle and hold counters), updated as each
// tick is taken, so ticks may follow back to back. Synchronous reset (aresetn
// low) empties the pipeline, restores the register reset values and leaves the
// controller idle with zero drives until a tick with a start request.
`default_nettype none
`include "drive_pid_with_heading_hold_assert.svh"
module drive_pid_with_heading_hold #(
    parameter int POS_WIDTH  = 24,
    parameter int HOLD_TICKS = 2
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [dph_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dph_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // s_tdata from bit 0: position, rotation_deg, zero fill
    input  wire logic [((POS_WIDTH+dph_pkg::ROT_W+7)/8)*8-1:0] s_tdata,
    // s_tuser: start_req
    input  wire logic                                  s_tuser,
    // Result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata from bit 0: left_drive, right_drive, zero fill
    output logic [((2*dph_pkg::DRIVE_W+7)/8)*8-1:0]    m_tdata,
    // m_tuser: done_res
    output logic                                       m_tuser
);

    localparam int OW         = dph_pkg::DRIVE_W;
    localparam int OUT_DATA_W = ((2*OW+7)/8)*8;
    localparam int RW         = dph_pkg::ROT_W;

    dph_pkg::cfg_t cfg;

    // Input register
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_start_reg;
    logic [POS_WIDTH-1:0]  s1_pos_reg;
    logic [RW-1:0]         s1_rot_reg;
    logic                  s_fire;

    // Core to mix
    logic                                core_in_ready;
    logic                                c_valid;
    logic                                c_ready;
    dph_pkg::mode_t                      c_mode;
    logic signed [POS_WIDTH:0]           c_err;
    logic signed [POS_WIDTH+1:0]         c_deriv;
    logic signed [dph_pkg::SUM_W-1:0]    c_sum;
    logic signed [dph_pkg::TURN_W-1:0]   c_turn;

    logic signed [OW-1:0]  left_drive;
    logic signed [OW-1:0]  right_drive;
    logic                  done_res;
    logic signed [OW-1:0]  drive_diff;

    assign cfg_ready = 1'b1;

    dph_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Take a new transaction when the input register is empty or draining
    assign s_tready = !s1_valid_reg || core_in_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (core_in_ready) begin
            s1_valid_next = 1'b0;
        end
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_start_reg <= s_tuser;
            s1_pos_reg   <= s_tdata[POS_WIDTH-1:0];
            s1_rot_reg   <= s_tdata[POS_WIDTH+RW-1:POS_WIDTH];
        end
    end

    dph_core #(
        .POS_WIDTH  (POS_WIDTH),
        .HOLD_TICKS (HOLD_TICKS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s1_valid_reg),
        .in_ready  (core_in_ready),
        .in_start  (s1_start_reg),
        .in_pos    (s1_pos_reg),
        .in_rot    (s1_rot_reg),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_mode  (c_mode),
        .out_err   (c_err),
        .out_deriv (c_deriv),
        .out_sum   (c_sum),
        .out_turn  (c_turn)
    );

    dph_mix #(
        .POS_WIDTH (POS_WIDTH)
    ) u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_mode   (c_mode),
        .in_err    (c_err),
        .in_deriv  (c_deriv),
        .in_sum    (c_sum),
        .in_turn   (c_turn),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_left  (left_drive),
        .out_right (right_drive),
        .out_done  (done_res)
    );

    assign m_tdata = {{(OUT_DATA_W-2*OW){1'b0}}, right_drive, left_drive};
    assign m_tuser = done_res;

    // Left minus right is twice the heading term, a whole number of degrees
    assign drive_diff = left_drive - right_drive;

    // A done result never carries a drive command
    `DPH_ASSERT_IMPLIES(a_done_zero, aclk, aresetn, m_tvalid && done_res,
        (left_drive == '0) && (right_drive == '0), "done result with nonzero drive")

    `DPH_ASSERT_RANGE(a_left_range, aclk, aresetn, m_tvalid, left_drive,
        -18'sd78592, 18'sd78592, "left drive out of range")

    `DPH_ASSERT_RANGE(a_right_range, aclk, aresetn, m_tvalid, right_drive,
        -18'sd78592, 18'sd78592, "right drive out of range")

    `DPH_ASSERT_IMPLIES(a_turn_grid, aclk, aresetn, m_tvalid,
        drive_diff[8:0] == 9'd0, "left/right difference off the heading grid")

endmodule
`default_nettype wire

// ===== hw/rtl/dph_cfg.sv =====
// Configuration register file of the drive PID block.
`default_nettype none
module dph_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_valid,
    input  wire logic [dph_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [dph_pkg::CFG_DATA_W-1:0] wr_data,
    output dph_pkg::cfg_t                       cfg
);

    dph_pkg::cfg_t cfg_reg;
    dph_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_valid) begin
            case (wr_index)
                dph_pkg::REG_GAIN_P:       cfg_next.gain_p        = wr_data[15:0];
                dph_pkg::REG_GAIN_I:       cfg_next.gain_i        = wr_data[15:0];
                dph_pkg::REG_GAIN_D:       cfg_next.gain_d        = wr_data[15:0];
                dph_pkg::REG_SPEED_LIMIT:  cfg_next.speed_limit   = wr_data[6:0];
                dph_pkg::REG_GOAL_POS:     cfg_next.goal_position = wr_data[23:0];
                dph_pkg::REG_SETTLE_BAND:  cfg_next.settle_band   = wr_data[15:0];
                dph_pkg::REG_SETTLE_TICKS: cfg_next.settle_ticks  = wr_data[7:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= dph_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dph_core.sv =====
// Controller state stage: error, integral, settle and hold logic, heading difference.
`default_nettype none
module dph_core #(
    parameter int POS_WIDTH  = 24,
    parameter int HOLD_TICKS = 2
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  var  dph_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          in_start,
    input  wire logic [POS_WIDTH-1:0]          in_pos,
    input  wire logic [dph_pkg::ROT_W-1:0]     in_rot,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output dph_pkg::mode_t                     out_mode,
    output logic signed [POS_WIDTH:0]          out_err,
    output logic signed [POS_WIDTH+1:0]        out_deriv,
    output logic signed [dph_pkg::SUM_W-1:0]   out_sum,
    output logic signed [dph_pkg::TURN_W-1:0]  out_turn
);

    localparam int EW = POS_WIDTH + 1;
    localparam int DW = POS_WIDTH + 2;
    localparam int SW = dph_pkg::SUM_W;
    localparam int HW = (HOLD_TICKS > 0) ? $clog2(HOLD_TICKS + 1) : 1;
    localparam int TW = dph_pkg::TURN_W;
    localparam logic [HW-1:0] HOLD_LIM = HW'(HOLD_TICKS);
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // Controller state
    logic signed [EW-1:0]           last_err_reg, last_err_next;
    logic signed [SW-1:0]           sum_reg, sum_next;
    logic [dph_pkg::HEAD_W-1:0]     head_reg, head_next;
    logic [HW-1:0]                  hold_reg, hold_next;
    logic [7:0]                     settled_reg, settled_next;
    logic                           running_reg, running_next;

    // Stage output
    logic                           valid_reg, valid_next;
    dph_pkg::mode_t                 mode_reg, mode_next;
    logic signed [DW-1:0]           deriv_reg, deriv_next;
    logic signed [TW-1:0]           turn_reg, turn_next;

    logic                           fire;
    logic                           run;
    logic [dph_pkg::HEAD_W-1:0]     cur;
    logic [dph_pkg::HEAD_W-1:0]     goal_head;
    logic signed [EW-1:0]           last_eff;
    logic signed [SW-1:0]           sum_eff;
    logic [HW-1:0]                  hold_eff;
    logic [7:0]                     settled_eff;
    logic [7:0]                     settled_upd;
    logic [POS_WIDTH-1:0]           goal_w;
    logic signed [EW-1:0]           err;
    logic signed [DW-1:0]           deriv;
    logic signed [SW:0]             sum_wide;
    logic signed [SW-1:0]           sum_sat;
    logic [EW-1:0]                  mag;
    logic                           in_band;
    logic signed [TW-1:0]           diff;
    logic signed [TW-1:0]           turn;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        cur         = dph_pkg::wrap_deg(in_rot);
        run         = in_start || running_reg;
        last_eff    = in_start ? '0 : last_err_reg;
        sum_eff     = in_start ? '0 : sum_reg;
        hold_eff    = in_start ? '0 : hold_reg;
        settled_eff = in_start ? '0 : settled_reg;
        goal_head   = in_start ? cur : head_reg;

        // Goal register is zero-extended or cut to the position width
        goal_w   = POS_WIDTH'(cfg.goal_position);
        err      = $signed({goal_w[POS_WIDTH-1], goal_w})
                 - $signed({in_pos[POS_WIDTH-1], in_pos});
        deriv    = $signed({err[EW-1], err}) - $signed({last_eff[EW-1], last_eff});

        sum_wide = $signed({sum_eff[SW-1], sum_eff})
                 + $signed({{(SW+1-EW){err[EW-1]}}, err});
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            sum_sat = sum_wide[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SW-1:0];
        end

        mag     = err[EW-1] ? EW'(-err) : EW'(err);
        in_band = mag < EW'(cfg.settle_band);

        // Shortest signed angle toward the latched heading
        diff = $signed({1'b0, goal_head}) - $signed({1'b0, cur});
        if (diff > TW'(dph_pkg::DEG_HALF)) begin
            turn = diff - TW'(dph_pkg::DEG_FULL);
        end else if (diff < -TW'(dph_pkg::DEG_HALF)) begin
            turn = diff + TW'(dph_pkg::DEG_FULL);
        end else begin
            turn = diff;
        end

        settled_upd = '0;
        if (in_band) begin
            settled_upd = (settled_eff == 8'hFF) ? settled_eff : settled_eff + 8'd1;
        end

        last_err_next = last_err_reg;
        sum_next      = sum_reg;
        head_next     = head_reg;
        hold_next     = hold_reg;
        settled_next  = settled_reg;
        running_next  = running_reg;
        mode_next     = mode_reg;
        deriv_next    = deriv_reg;
        turn_next     = turn_reg;
        valid_next    = valid_reg;

        if (out_ready) begin
            valid_next = 1'b0;
        end

        if (fire) begin
            valid_next = 1'b1;
            deriv_next = deriv;
            turn_next  = turn;
            mode_next  = dph_pkg::MODE_ZERO;
            if (run) begin
                last_err_next = err;
                sum_next      = (cfg.gain_i != 16'd0) ? sum_sat : sum_eff;
                head_next     = goal_head;
                running_next  = 1'b1;
                if (hold_eff < HOLD_LIM) begin
                    hold_next    = hold_eff + HW'(1);
                    settled_next = settled_eff;
                end else begin
                    hold_next    = hold_eff;
                    settled_next = settled_upd;
                    if (settled_upd > cfg.settle_ticks) begin
                        running_next = 1'b0;
                        mode_next    = dph_pkg::MODE_DONE;
                    end else begin
                        mode_next    = dph_pkg::MODE_DRIVE;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            sum_reg      <= '0;
            head_reg     <= '0;
            hold_reg     <= '0;
            settled_reg  <= '0;
            running_reg  <= 1'b0;
            valid_reg    <= 1'b0;
            mode_reg     <= dph_pkg::MODE_ZERO;
        end else begin
            last_err_reg <= last_err_next;
            sum_reg      <= sum_next;
            head_reg     <= head_next;
            hold_reg     <= hold_next;
            settled_reg  <= settled_next;
            running_reg  <= running_next;
            valid_reg    <= valid_next;
            mode_reg     <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        deriv_reg <= deriv_next;
        turn_reg  <= turn_next;
    end

    // Error and integral of a running tick's transaction are the freshly written state
    assign out_valid = valid_reg;
    assign out_mode  = mode_reg;
    assign out_err   = last_err_reg;
    assign out_sum   = sum_reg;
    assign out_deriv = deriv_reg;
    assign out_turn  = turn_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dph_mix.sv =====
// Gain products, PID sum, clamp and left/right mixing, three register stages.
`default_nettype none
module dph_mix #(
    parameter int POS_WIDTH = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  var  dph_pkg::cfg_t                  cfg,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  var  dph_pkg::mode_t                 in_mode,
    input  wire logic signed [POS_WIDTH:0]      in_err,
    input  wire logic signed [POS_WIDTH+1:0]    in_deriv,
    input  wire logic signed [dph_pkg::SUM_W-1:0]  in_sum,
    input  wire logic signed [dph_pkg::TURN_W-1:0] in_turn,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [dph_pkg::DRIVE_W-1:0]  out_left,
    output logic signed [dph_pkg::DRIVE_W-1:0]  out_right,
    output logic                                out_done
);

    localparam int EW  = POS_WIDTH + 1;
    localparam int DW  = POS_WIDTH + 2;
    localparam int SW  = dph_pkg::SUM_W;
    localparam int TW  = dph_pkg::TURN_W;
    localparam int OW  = dph_pkg::DRIVE_W;
    localparam int PPW = EW + 17;
    localparam int IPW = SW + 17;
    localparam int DPW = DW + 17;
    localparam int PW  = ((IPW > DPW) ? IPW : DPW) + 2;

    // Stage A: products
    logic                  a_valid_reg, a_valid_next;
    dph_pkg::mode_t        a_mode_reg;
    logic signed [PPW-1:0] p_reg, p_next;
    logic signed [IPW-1:0] i_reg, i_next;
    logic signed [DPW-1:0] d_reg, d_next;
    logic signed [TW-1:0]  a_turn_reg;

    // Stage B: PID sum
    logic                  b_valid_reg, b_valid_next;
    dph_pkg::mode_t        b_mode_reg;
    logic signed [PW-1:0]  pid_reg, pid_next;
    logic signed [TW-1:0]  b_turn_reg;

    // Result register
    logic                  o_valid_reg, o_valid_next;
    logic signed [OW-1:0]  left_reg, left_next;
    logic signed [OW-1:0]  right_reg, right_next;
    logic                  done_reg, done_next;

    logic                  o_ready, b_ready, a_ready;
    logic                  a_load, b_load, o_load;
    logic signed [PW-1:0]  lim_s;
    logic signed [OW-1:0]  pc;
    logic signed [OW-1:0]  h;

    assign o_ready  = !o_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || o_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign a_load   = in_valid && a_ready;
    assign b_load   = a_valid_reg && b_ready;
    assign o_load   = b_valid_reg && o_ready;

    always_comb begin
        p_next   = $signed({1'b0, cfg.gain_p}) * in_err;
        i_next   = $signed({1'b0, cfg.gain_i}) * in_sum;
        d_next   = $signed({1'b0, cfg.gain_d}) * in_deriv;
        pid_next = PW'(p_reg) + PW'(i_reg) + PW'(d_reg);

        lim_s = $signed({{(PW-15){1'b0}}, cfg.speed_limit, 8'h00});
        if (pid_reg > lim_s) begin
            pc = lim_s[OW-1:0];
        end else if (pid_reg < -lim_s) begin
            pc = OW'(-lim_s);
        end else begin
            pc = pid_reg[OW-1:0];
        end
        h = $signed({b_turn_reg, 8'h00});

        if (b_mode_reg == dph_pkg::MODE_DRIVE) begin
            left_next  = pc + h;
            right_next = pc - h;
        end else begin
            left_next  = '0;
            right_next = '0;
        end
        done_next = (b_mode_reg == dph_pkg::MODE_DONE);

        a_valid_next = a_load ? 1'b1 : (b_ready ? 1'b0 : a_valid_reg);
        b_valid_next = b_load ? 1'b1 : (o_ready ? 1'b0 : b_valid_reg);
        o_valid_next = o_load ? 1'b1 : (out_ready ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_mode_reg <= in_mode;
            p_reg      <= p_next;
            i_reg      <= i_next;
            d_reg      <= d_next;
            a_turn_reg <= in_turn;
        end
        if (b_load) begin
            b_mode_reg <= a_mode_reg;
            pid_reg    <= pid_next;
            b_turn_reg <= a_turn_reg;
        end
        if (o_load) begin
            left_reg  <= left_next;
            right_reg <= right_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign out_done  = done_reg;

endmodule
`default_nettype wire

// ===== tb/sv/drive_pid_with_heading_hold_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the drive PID with heading hold block.
module drive_pid_with_heading_hold_tb;

    localparam int ROT_W        = dph_pkg::ROT_W;
    localparam int DRIVE_W      = dph_pkg::DRIVE_W;
    localparam int GOAL_W       = dph_pkg::GOAL_W;
    localparam int CFG_IDX_W    = dph_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = dph_pkg::CFG_DATA_W;
    localparam int DEG_FULL     = dph_pkg::DEG_FULL;
    localparam int DEG_HALF     = dph_pkg::DEG_HALF;
    localparam int POS_W        = 24;
    localparam int HOLD_TICKS   = 2;
    localparam int S_DATA_W     = ((POS_W + ROT_W + 7) / 8) * 8;
    localparam int M_DATA_W     = ((2 * DRIVE_W + 7) / 8) * 8;
    // No transaction on any channel for this many cycles ends the run.
    // Longest legal quiet stretch is a long sink hold-off plus a long gap.
    localparam int STALL_LIMIT  = 4000;
    // Extra wait after the last result so that the pipeline is sure to be empty.
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 60;
    localparam longint INTEG_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam longint INTEG_MIN = -64'sh0000_0080_0000_0000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // position, rotation_deg, zero fill
    logic                  s_tuser;   // start_req
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;   // left_drive, right_drive, zero fill
    logic                  m_tuser;   // done_res

    // One expected result: both drive commands and the done flag
    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        logic                      done;
    } drive_cmd_t;

    drive_cmd_t cmds_due[$];

    // Predictor copy of the registers and the controller state
    dph_pkg::cfg_t ctl_cfg;
    longint prev_error;
    longint error_integral;
    int     heading_hold;
    int     hold_ticks_seen;
    int     settle_run;
    bit     moving;

    // Traffic shaping, shared with the sink process
    bit feed_gaps         = 1'b1;
    bit sink_steady       = 1'b0;
    int sink_hold_cycles  = 0;

    int mismatches    = 0;
    int ticks_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int moves_settled = 0;
    int quiet_cycles  = 0;

    drive_pid_with_heading_hold #(
        .POS_WIDTH (POS_W),
        .HOLD_TICKS(HOLD_TICKS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic reset_controller_model();
        ctl_cfg.gain_p        = 16'd768;
        ctl_cfg.gain_i        = 16'd0;
        ctl_cfg.gain_d        = 16'd6400;
        ctl_cfg.speed_limit   = 7'd110;
        ctl_cfg.goal_position = 24'd0;
        ctl_cfg.settle_band   = 16'd100;
        ctl_cfg.settle_ticks  = 8'd10;
        prev_error      = 0;
        error_integral  = 0;
        heading_hold    = 0;
        hold_ticks_seen = 0;
        settle_run      = 0;
        moving          = 1'b0;
    endtask

    // Gyro rotation folded into 0..359 degrees
    function automatic int heading_mod360(logic [ROT_W-1:0] rot);
        int d;
        d = int'($signed(rot)) % DEG_FULL;
        if (d < 0) d += DEG_FULL;
        return d;
    endfunction

    // Advance the controller by one tick and return the command it issues
    function automatic drive_cmd_t controller_tick(logic start, logic [POS_W-1:0] pos_bits,
                                                   logic [ROT_W-1:0] rot_bits);
        longint pos, goal, err, deriv, pid, lim, mag, acc, turn, steer;
        int cur;
        drive_cmd_t cmd;
        pos  = longint'($signed(pos_bits));
        goal = longint'($signed(ctl_cfg.goal_position));
        cur  = heading_mod360(rot_bits);
        cmd  = '0;
        if (start) begin
            prev_error      = 0;
            error_integral  = 0;
            hold_ticks_seen = 0;
            settle_run      = 0;
            heading_hold    = cur;
            moving          = 1'b1;
        end
        if (!moving) return cmd;

        err   = goal - pos;
        deriv = err - prev_error;
        // Integral only accumulates with a nonzero gain, and saturates
        if (ctl_cfg.gain_i != 0) begin
            acc = error_integral + err;
            if (acc > INTEG_MAX) acc = INTEG_MAX;
            else if (acc < INTEG_MIN) acc = INTEG_MIN;
            error_integral = acc;
        end
        pid = longint'(ctl_cfg.gain_p) * err + longint'(ctl_cfg.gain_i) * error_integral
            + longint'(ctl_cfg.gain_d) * deriv;
        lim = longint'(ctl_cfg.speed_limit) * 256;
        if (pid > lim) pid = lim;
        else if (pid < -lim) pid = -lim;
        prev_error = err;

        // Shortest signed angle back to the latched heading
        turn = longint'(heading_hold - cur);
        if (turn > DEG_HALF) turn -= DEG_FULL;
        else if (turn < -DEG_HALF) turn += DEG_FULL;
        steer = turn * 256;

        if (hold_ticks_seen < HOLD_TICKS) begin
            hold_ticks_seen++;
            return cmd;
        end

        mag = (err < 0) ? -err : err;
        if (mag < longint'(ctl_cfg.settle_band)) begin
            if (settle_run < 255) settle_run++;
        end else begin
            settle_run = 0;
        end
        if (settle_run > int'(ctl_cfg.settle_ticks)) begin
            moving   = 1'b0;
            cmd.done = 1'b1;
            moves_settled++;
            return cmd;
        end
        cmd.left  = DRIVE_W'(pid + steer);
        cmd.right = DRIVE_W'(pid - steer);
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Drivers (all enter and leave at a falling edge)
    // ------------------------------------------------------------------

    // Mostly short pauses, now and then a long one
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic write_register(dph_pkg::cfg_reg_t idx,
                                  logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            dph_pkg::REG_GAIN_P:       ctl_cfg.gain_p        = value[15:0];
            dph_pkg::REG_GAIN_I:       ctl_cfg.gain_i        = value[15:0];
            dph_pkg::REG_GAIN_D:       ctl_cfg.gain_d        = value[15:0];
            dph_pkg::REG_SPEED_LIMIT:  ctl_cfg.speed_limit   = value[6:0];
            dph_pkg::REG_GOAL_POS:     ctl_cfg.goal_position = value[GOAL_W-1:0];
            dph_pkg::REG_SETTLE_BAND:  ctl_cfg.settle_band   = value[15:0];
            dph_pkg::REG_SETTLE_TICKS: ctl_cfg.settle_ticks  = value[7:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Offer one control tick, wait for its transaction, then predict its result
    task automatic send_tick(logic start, logic [POS_W-1:0] pos, logic [ROT_W-1:0] rot);
        int gap;
        gap = (feed_gaps && $urandom_range(0, 9) >= 6) ? pause_length() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = start;
        s_tdata  = S_DATA_W'({rot, pos});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmds_due.push_back(controller_tick(start, pos, rot));
        ticks_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Stop feeding until every expected result has come back, then let the pipe empty
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (cmds_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // One move: a start tick, then positions closing in on the goal
    task automatic run_move(int n_ticks, int spread, logic [ROT_W-1:0] rot0);
        int offset;
        int rot;
        offset = int'($urandom_range(0, 2 * spread)) - spread;
        rot    = int'($signed(rot0));
        for (int k = 0; k < n_ticks; k++) begin
            rot += int'($urandom_range(0, 20)) - 10;
            send_tick(k == 0, POS_W'(longint'($signed(ctl_cfg.goal_position)) - offset),
                      ROT_W'(rot));
            offset = offset * 3 / 4 + int'($urandom_range(0, 6)) - 3;
        end
    endtask

    // Either end of the range now and then, otherwise something typical
    function automatic int pick_setting(int top, int typical);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return top;
        return $urandom_range(0, typical);
    endfunction

    task automatic shuffle_tuning();
        int r;
        write_register(dph_pkg::REG_GAIN_P, CFG_DATA_W'(pick_setting(65535, 1024)));
        write_register(dph_pkg::REG_GAIN_I, CFG_DATA_W'(($urandom_range(0, 2) == 0)
                                                        ? 0 : pick_setting(65535, 48)));
        write_register(dph_pkg::REG_GAIN_D, CFG_DATA_W'(pick_setting(65535, 2048)));
        write_register(dph_pkg::REG_SPEED_LIMIT, CFG_DATA_W'(pick_setting(127, 127)));
        r = $urandom_range(0, 4);
        write_register(dph_pkg::REG_GOAL_POS, (r == 0) ? 24'h7FFFFF :
                                              (r == 1) ? 24'h800000 : CFG_DATA_W'($urandom));
        write_register(dph_pkg::REG_SETTLE_BAND, CFG_DATA_W'(pick_setting(65535, 2000)));
        write_register(dph_pkg::REG_SETTLE_TICKS, CFG_DATA_W'(pick_setting(255, 10)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle controller: no start means zero drives whatever the sensors say
    task automatic test_idle_after_reset();
        send_tick(1'b0, 24'h7FFFFF, 16'h8000);
        send_tick(1'b0, 24'h800000, 16'h7FFF);
        wait_for_results();
    endtask

    // A move on the reset tuning with sensor extremes; heading latched from -32768
    task automatic test_reset_tuning_move();
        send_tick(1'b1, 24'h7FFFFF, 16'h8000);
        send_tick(1'b0, 24'h800000, 16'h7FFF);
        send_tick(1'b0, 24'h800000, 16'h7FFF);
        send_tick(1'b0, 24'd50, 16'hFFFF);
        send_tick(1'b0, 24'd0, 16'd352);
        wait_for_results();
    endtask

    // Zero speed limit leaves only the heading term: walk the +/-180 boundary
    task automatic test_heading_wrap();
        write_register(dph_pkg::REG_SPEED_LIMIT, '0);
        write_register(dph_pkg::REG_GAIN_P, 24'd65535);
        write_register(dph_pkg::REG_GAIN_D, '0);
        send_tick(1'b1, 24'd5000, 16'd0);
        send_tick(1'b0, 24'd5000, 16'd0);
        send_tick(1'b0, 24'd5000, 16'd180);
        send_tick(1'b0, 24'd5000, ROT_W'(-180));
        send_tick(1'b0, 24'd5000, 16'd181);
        send_tick(1'b0, 24'd5000, ROT_W'(-181));
        // restart mid-move with the heading at 359
        send_tick(1'b1, 24'd5000, 16'd359);
        send_tick(1'b0, 24'd5000, 16'd0);
        send_tick(1'b0, 24'd5000, 16'd178);
        send_tick(1'b0, 24'd5000, 16'd179);
        send_tick(1'b0, 24'd5000, 16'hFFFF);
        send_tick(1'b0, 24'd5000, 16'd0);
        wait_for_results();
    endtask

    // Settle at once with zero settle ticks, then a band of zero that never settles
    task automatic test_settle_done();
        write_register(dph_pkg::REG_SETTLE_TICKS, '0);
        write_register(dph_pkg::REG_SETTLE_BAND, 24'd65535);
        write_register(dph_pkg::REG_SPEED_LIMIT, 24'd127);
        write_register(dph_pkg::REG_GAIN_I, 24'd65535);
        write_register(dph_pkg::REG_GOAL_POS, 24'h800000);
        send_tick(1'b1, 24'h800000, 16'd10);
        send_tick(1'b0, 24'h800000, 16'd10);
        send_tick(1'b0, 24'h800000, 16'd10);
        send_tick(1'b0, 24'h800000, 16'd10);
        send_tick(1'b0, 24'h800000, 16'd10);
        wait_for_results();
        write_register(dph_pkg::REG_SETTLE_BAND, '0);
        send_tick(1'b1, 24'h7FFFFF, 16'd90);
        send_tick(1'b0, 24'h7FFFFF, 16'd90);
        send_tick(1'b0, 24'h7FFFFF, 16'd90);
        send_tick(1'b0, 24'h7FFFFF, 16'd0);
        wait_for_results();
    endtask

    // Settle counter must stick at 255: with 255 nothing ends, then 254 ends next tick
    task automatic test_settle_count_saturation();
        write_register(dph_pkg::REG_SETTLE_TICKS, 24'd255);
        write_register(dph_pkg::REG_SETTLE_BAND, 24'd65535);
        write_register(dph_pkg::REG_GOAL_POS, '0);
        write_register(dph_pkg::REG_GAIN_I, 24'd3);
        write_register(dph_pkg::REG_GAIN_P, 24'd256);
        for (int k = 0; k < 262; k++)
            send_tick(k == 0, POS_W'(int'($urandom_range(0, 2000)) - 1000),
                      ROT_W'($urandom));
        wait_for_results();
        write_register(dph_pkg::REG_SETTLE_TICKS, 24'd254);
        send_tick(1'b0, 24'd7, 16'd1);
        send_tick(1'b0, 24'd7, 16'd1);
        wait_for_results();
    endtask

    // Sink holds off long enough to fill every stage; then a pause and the move goes on
    task automatic test_backpressure();
        write_register(dph_pkg::REG_GAIN_P, 24'd300);
        write_register(dph_pkg::REG_GAIN_I, 24'd2);
        write_register(dph_pkg::REG_GAIN_D, 24'd900);
        write_register(dph_pkg::REG_SETTLE_TICKS, 24'd200);
        write_register(dph_pkg::REG_SETTLE_BAND, 24'd50);
        write_register(dph_pkg::REG_GOAL_POS, 24'd123456);
        feed_gaps        = 1'b0;
        sink_hold_cycles = 80;
        run_move(30, 4000, ROT_W'($urandom));
        wait_for_results();
        for (int k = 0; k < 8; k++)
            send_tick(1'b0, POS_W'(123456 - 20 * k), ROT_W'($urandom));
        wait_for_results();
        feed_gaps = 1'b1;
    endtask

    // Random tuning per phase; mostly whole moves, some noise ticks and pauses
    task automatic test_random_traffic();
        int sent_here;
        int len;
        int spread;
        for (int phase = 0; phase < 2; phase++) begin
            feed_gaps   = (phase % 3 != 0);
            sink_steady = (phase % 3 == 0);
            shuffle_tuning();
            sent_here = 0;
            while (sent_here < 60) begin
                if ($urandom_range(0, 99) < 80) begin
                    len    = $urandom_range(4, 24);
                    spread = int'(ctl_cfg.settle_band) * 2 + int'($urandom_range(0, 3000));
                    run_move(len, spread, ROT_W'($urandom));
                    sent_here += len;
                end else begin
                    send_tick($urandom_range(0, 7) == 0, POS_W'($urandom), ROT_W'($urandom));
                    sent_here++;
                end
                if ($urandom_range(0, 19) == 0) wait_for_results();
            end
            wait_for_results();
        end
        feed_gaps   = 1'b1;
        sink_steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, steady stretches, and a counted hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_tready = 1'b0;
                sink_hold_cycles--;
            end else if (sink_steady) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready   = 1'b0;
                stall_left = pause_length() - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Count a mismatch; only the first few are printed to keep the log short
    function automatic void flag_mismatch(string field, longint want, longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        else if (mismatches == MAX_REPORTS + 1)
            $display("Further mismatches are counted without a report");
    endfunction

    // Compare each result transaction against the oldest expected command
    always @(posedge aclk) begin : result_check
        drive_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (cmds_due.size() == 0) begin
                mismatches++;
                $error("result transaction with no tick outstanding");
            end else begin
                want = cmds_due.pop_front();
                if (m_tdata[DRIVE_W-1:0] !== want.left)
                    flag_mismatch("left_drive", want.left,
                                  longint'($signed(m_tdata[DRIVE_W-1:0])));
                if (m_tdata[2*DRIVE_W-1:DRIVE_W] !== want.right)
                    flag_mismatch("right_drive", want.right,
                                  longint'($signed(m_tdata[2*DRIVE_W-1:DRIVE_W])));
                if (m_tuser !== want.done)
                    flag_mismatch("done_res", want.done, longint'(m_tuser));
                if (m_tdata[M_DATA_W-1:2*DRIVE_W] !== '0)
                    flag_mismatch("m_tdata fill", 0, longint'(m_tdata[M_DATA_W-1:2*DRIVE_W]));
            end
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles, %0d results outstanding",
                   quiet_cycles, cmds_due.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = dph_pkg::REG_GAIN_P;
        cfg_data  = '0;
        reset_controller_model();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_after_reset();
        test_reset_tuning_move();
        test_heading_wrap();
        test_settle_done();
        test_settle_count_saturation();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        $display("Sent %0d ticks, checked %0d results, %0d moves settled, %0d register writes.",
                 ticks_sent, results_seen, moves_settled, reg_writes);
        $display("Covered idle, hold, restart, heading wrap, settle limits, stalls, random tuning.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
